[rtl/mtirp_pkg.sv]
// types, widths and constants shared by the impedance / resistivity / phase pipeline
`default_nettype none
package mtirp_pkg;

   localparam int CW           = 32;   // one field component, signed Q8.24
   localparam int NW           = 66;   // numerator / determinant component
   localparam int PW           = 133;  // cross products N * conj(D)
   localparam int MW           = 132;  // squared magnitudes
   localparam int RW           = 48;   // resistivity and its scale register
   localparam int QW           = 180;  // dividend |N|^2 * inv_omega_mu
   localparam int XW           = 33;   // cordic x / y
   localparam int ZW           = 25;   // cordic angle, degrees Q.16
   localparam int FIT_BITS     = 30;
   localparam int NORM_STEPS   = 7;
   localparam int CORDIC_STEPS = 20;
   localparam int PHASE_LIM    = 23040;

   typedef logic signed [ZW-1:0] ang_type;

   localparam ang_type ATAN_TBL [CORDIC_STEPS] = '{
      25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945, 25'sd234379,
      25'sd117304,  25'sd58666,   25'sd29335,  25'sd14668,  25'sd7334,
      25'sd3667,    25'sd1833,    25'sd917,    25'sd458,    25'sd229,
      25'sd115,     25'sd57,      25'sd29,     25'sd14,     25'sd7
   };

   typedef struct packed {
      logic signed [CW-1:0] re;
      logic signed [CW-1:0] im;
   } cpx_type;

   typedef struct packed {
      logic [63:0] ex_pol1;
      logic [63:0] ey_pol1;
      logic [63:0] hx_pol1;
      logic [63:0] hy_pol1;
      logic [63:0] ex_pol2;
      logic [63:0] ey_pol2;
      logic [63:0] hx_pol2;
      logic [63:0] hy_pol2;
   } req_type;

   typedef struct packed {
      logic signed [15:0] phase_xx;
      logic signed [15:0] phase_xy;
      logic signed [15:0] phase_yx;
      logic signed [15:0] phase_yy;
      logic [RW-1:0]      rho_xx;
      logic [RW-1:0]      rho_xy;
      logic [RW-1:0]      rho_yx;
      logic [RW-1:0]      rho_yy;
      logic               status;
   } rsp_type;

   typedef struct packed {
      logic im_zero;
      logic re_zero;
      logic im_neg;
      logic pos;
   } phflag_type;

   typedef struct packed {
      logic [PW-1:0] xa;
      logic [PW-1:0] ya;
      logic [PW-1:0] mx;
      phflag_type    flg;
   } norm_type;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      ang_type              z;
      phflag_type           flg;
   } cord_type;

   typedef struct packed {
      logic [QW-1:0] rem;
      logic [MW-1:0] den;
      logic [RW-1:0] quo;
      logic          ovf;
   } div_type;

endpackage
`default_nettype wire

[rtl/mt_impedance_resistivity_phase_core.sv]
// top level: impedance tensor, apparent resistivity and phase per station
// throughput: one station per cycle; busy stays low, every beat is taken
// the 48-cell divider chain sets the depth, the phase path is delayed to match
// reset clears the valid pipeline, the strobe and inv_omega_mu (to 0)
// the receiver cannot stall, results appear for exactly one cycle
`default_nettype none
module mt_impedance_resistivity_phase_core import mtirp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  req_type       req_data,
   output logic          rsp_valid,
   output rsp_type       rsp_data,
   input  logic          csr_we,
   input  logic [RW-1:0] csr_wdata
);
   localparam int PH_LAT  = 1 + NORM_STEPS + CORDIC_STEPS + 1;
   localparam int RHO_LAT = 2 + 1 + RW;
   localparam int PH_DLY  = RHO_LAT - PH_LAT;
   localparam int LAST    = 6 + RHO_LAT;
   localparam int NPAIR   = 5;

   // operand pairs: determinant first, then the four numerators
   localparam int OPA1 [NPAIR] = '{2, 0, 4, 1, 5};
   localparam int OPB1 [NPAIR] = '{7, 7, 2, 7, 2};
   localparam int OPA2 [NPAIR] = '{3, 4, 0, 5, 1};
   localparam int OPB2 [NPAIR] = '{6, 3, 6, 3, 6};

   typedef struct packed {
      logic signed [2*CW-1:0] rr;
      logic signed [2*CW-1:0] ii;
      logic signed [2*CW-1:0] ri;
      logic signed [2*CW-1:0] ir;
   } cprod_type;

   typedef struct packed {
      logic signed [NW-1:0] re;
      logic signed [NW-1:0] im;
   } wcpx_type;

   logic                     accept;
   logic [RW-1:0]            iom_ff;
   logic [LAST:1]            vld_ff;
   logic [LAST:4]            dz_ff;
   req_type                  req_ff;
   cpx_type                  opnd [8];
   cprod_type                prod_ff [NPAIR][2];
   wcpx_type                 w_ff [NPAIR];
   logic signed [2*NW-1:0]   dre2;
   logic signed [2*NW-1:0]   dim2;
   logic [MW-1:0]            dm2_ff;
   logic [MW-1:0]            dm2_d1_ff;
   logic [MW-1:0]            dm2_d2_ff;
   logic [3:0][15:0]         ph_ff;
   logic [3:0][15:0]         ph_dly_ff [PH_DLY];
   logic [3:0][RW-1:0]       rho_fin;
   rsp_type                  rsp_ff;
   logic                     rsp_valid_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         iom_ff       <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            iom_ff <= csr_wdata;
         end
         vld_ff       <= {vld_ff[LAST-1:1], accept};
         rsp_valid_ff <= vld_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      dz_ff <= {dz_ff[LAST-1:4], (w_ff[0] == '0)};
   end

   assign opnd[0] = cpx_type'(req_ff.ex_pol1);
   assign opnd[1] = cpx_type'(req_ff.ey_pol1);
   assign opnd[2] = cpx_type'(req_ff.hx_pol1);
   assign opnd[3] = cpx_type'(req_ff.hy_pol1);
   assign opnd[4] = cpx_type'(req_ff.ex_pol2);
   assign opnd[5] = cpx_type'(req_ff.ey_pol2);
   assign opnd[6] = cpx_type'(req_ff.hx_pol2);
   assign opnd[7] = cpx_type'(req_ff.hy_pol2);

   // complex products and the differences that form D and N
   for (genvar gp = 0; gp < NPAIR; gp++) begin : g_pair
      for (genvar gs = 0; gs < 2; gs++) begin : g_side
         localparam int IA = (gs == 0) ? OPA1[gp] : OPA2[gp];
         localparam int IB = (gs == 0) ? OPB1[gp] : OPB2[gp];
         always_ff @(posedge clock) begin
            prod_ff[gp][gs].rr <= opnd[IA].re * opnd[IB].re;
            prod_ff[gp][gs].ii <= opnd[IA].im * opnd[IB].im;
            prod_ff[gp][gs].ri <= opnd[IA].re * opnd[IB].im;
            prod_ff[gp][gs].ir <= opnd[IA].im * opnd[IB].re;
         end
      end
      always_ff @(posedge clock) begin
         w_ff[gp].re <= NW'(prod_ff[gp][0].rr) - NW'(prod_ff[gp][0].ii)
                      - NW'(prod_ff[gp][1].rr) + NW'(prod_ff[gp][1].ii);
         w_ff[gp].im <= NW'(prod_ff[gp][0].ri) + NW'(prod_ff[gp][0].ir)
                      - NW'(prod_ff[gp][1].ri) - NW'(prod_ff[gp][1].ir);
      end
   end

   mtirp_mul #(.WA(NW), .WB(NW)) u_dre2 (
      .clock (clock), .a (w_ff[0].re), .b (w_ff[0].re), .p (dre2));
   mtirp_mul #(.WA(NW), .WB(NW)) u_dim2 (
      .clock (clock), .a (w_ff[0].im), .b (w_ff[0].im), .p (dim2));

   always_ff @(posedge clock) begin
      dm2_ff    <= MW'(dre2) + MW'(dim2);
      dm2_d1_ff <= dm2_ff;
      dm2_d2_ff <= dm2_d1_ff;
   end

   for (genvar gk = 0; gk < 4; gk++) begin : g_elem
      logic signed [2*NW-1:0]  m_rr;
      logic signed [2*NW-1:0]  m_ii;
      logic signed [2*NW-1:0]  m_ir;
      logic signed [2*NW-1:0]  m_ri;
      logic signed [2*NW-1:0]  m_r2;
      logic signed [2*NW-1:0]  m_i2;
      logic signed [PW-1:0]    pre_ff;
      logic signed [PW-1:0]    pim_ff;
      logic [MW-1:0]           nm2_ff;
      norm_type                nrm_in;
      norm_type                nrm_c [NORM_STEPS+1];
      cord_type                crd_c [CORDIC_STEPS+1];
      logic signed [MW+RW+1:0] num;
      div_type                 div_c [RW+1];
      logic [ZW-1:0]           zpos;
      logic [ZW:0]             rnd;
      logic [ZW-8:0]           magw;
      logic [15:0]             mag;
      logic [15:0]             ph_in;

      mtirp_mul #(.WA(NW), .WB(NW)) u_rr (
         .clock (clock), .a (w_ff[gk+1].re), .b (w_ff[0].re), .p (m_rr));
      mtirp_mul #(.WA(NW), .WB(NW)) u_ii (
         .clock (clock), .a (w_ff[gk+1].im), .b (w_ff[0].im), .p (m_ii));
      mtirp_mul #(.WA(NW), .WB(NW)) u_ir (
         .clock (clock), .a (w_ff[gk+1].im), .b (w_ff[0].re), .p (m_ir));
      mtirp_mul #(.WA(NW), .WB(NW)) u_ri (
         .clock (clock), .a (w_ff[gk+1].re), .b (w_ff[0].im), .p (m_ri));
      mtirp_mul #(.WA(NW), .WB(NW)) u_r2 (
         .clock (clock), .a (w_ff[gk+1].re), .b (w_ff[gk+1].re), .p (m_r2));
      mtirp_mul #(.WA(NW), .WB(NW)) u_i2 (
         .clock (clock), .a (w_ff[gk+1].im), .b (w_ff[gk+1].im), .p (m_i2));

      always_ff @(posedge clock) begin
         pre_ff <= PW'(m_rr) + PW'(m_ii);
         pim_ff <= PW'(m_ir) - PW'(m_ri);
         nm2_ff <= MW'(m_r2) + MW'(m_i2);
      end

      // phase path: magnitudes, normalize, cordic
      always_comb begin
         nrm_in.xa          = pre_ff[PW-1] ? PW'(-pre_ff) : PW'(pre_ff);
         nrm_in.ya          = pim_ff[PW-1] ? PW'(-pim_ff) : PW'(pim_ff);
         nrm_in.mx          = (nrm_in.xa >= nrm_in.ya) ? nrm_in.xa : nrm_in.ya;
         nrm_in.flg.im_zero = (pim_ff == '0);
         nrm_in.flg.re_zero = (pre_ff == '0);
         nrm_in.flg.im_neg  = pim_ff[PW-1];
         nrm_in.flg.pos     = (pim_ff[PW-1] == pre_ff[PW-1]);
      end

      always_ff @(posedge clock) begin
         nrm_c[0] <= nrm_in;
      end

      for (genvar gn = 0; gn < NORM_STEPS; gn++) begin : g_norm
         mtirp_norm_cell #(.SHIFT((1 << (NORM_STEPS-1)) >> gn)) u_norm (
            .clock  (clock),
            .cell_i (nrm_c[gn]),
            .cell_o (nrm_c[gn+1]));
      end

      assign crd_c[0].x   = XW'(nrm_c[NORM_STEPS].xa[FIT_BITS-1:0]);
      assign crd_c[0].y   = XW'(nrm_c[NORM_STEPS].ya[FIT_BITS-1:0]);
      assign crd_c[0].z   = '0;
      assign crd_c[0].flg = nrm_c[NORM_STEPS].flg;

      for (genvar gc = 0; gc < CORDIC_STEPS; gc++) begin : g_cord
         mtirp_cordic_cell #(.STEP(gc)) u_cord (
            .clock  (clock),
            .cell_i (crd_c[gc]),
            .cell_o (crd_c[gc+1]));
      end

      always_comb begin
         zpos = crd_c[CORDIC_STEPS].z[ZW-1] ? '0 : crd_c[CORDIC_STEPS].z;
         rnd  = {1'b0, zpos} + (ZW+1)'(128);
         magw = rnd[ZW:8];
         mag  = (magw > (ZW-7)'(PHASE_LIM)) ? 16'(PHASE_LIM) : magw[15:0];
         if (crd_c[CORDIC_STEPS].flg.im_zero) begin
            ph_in = '0;
         end else if (crd_c[CORDIC_STEPS].flg.re_zero) begin
            ph_in = crd_c[CORDIC_STEPS].flg.im_neg ? 16'(PHASE_LIM) : -16'(PHASE_LIM);
         end else begin
            ph_in = crd_c[CORDIC_STEPS].flg.pos ? -mag : mag;
         end
      end

      always_ff @(posedge clock) begin
         ph_ff[gk] <= ph_in;
      end

      // resistivity path: scale, overflow check, then one quotient bit per cell
      mtirp_mul #(.WA(MW+1), .WB(RW+1)) u_scale (
         .clock (clock),
         .a     ($signed({1'b0, nm2_ff})),
         .b     ($signed({1'b0, iom_ff})),
         .p     (num));

      always_ff @(posedge clock) begin
         div_c[0].rem <= num[QW-1:0];
         div_c[0].den <= dm2_d2_ff;
         div_c[0].quo <= '0;
         div_c[0].ovf <= (num[QW-1:0] >= (QW'(dm2_d2_ff) << RW));
      end

      for (genvar gd = 0; gd < RW; gd++) begin : g_div
         mtirp_div_cell #(.BIT(RW-1-gd)) u_div (
            .clock  (clock),
            .cell_i (div_c[gd]),
            .cell_o (div_c[gd+1]));
      end

      assign rho_fin[gk] = div_c[RW].ovf ? {RW{1'b1}} : div_c[RW].quo;
   end

   always_ff @(posedge clock) begin
      ph_dly_ff[0] <= ph_ff;
      for (int i = 1; i < PH_DLY; i++) begin
         ph_dly_ff[i] <= ph_dly_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (dz_ff[LAST]) begin
         rsp_ff <= '{status: 1'b1, default: '0};
      end else begin
         rsp_ff.phase_xx <= ph_dly_ff[PH_DLY-1][0];
         rsp_ff.phase_xy <= ph_dly_ff[PH_DLY-1][1];
         rsp_ff.phase_yx <= ph_dly_ff[PH_DLY-1][2];
         rsp_ff.phase_yy <= ph_dly_ff[PH_DLY-1][3];
         rsp_ff.rho_xx   <= rho_fin[0];
         rsp_ff.rho_xy   <= rho_fin[1];
         rsp_ff.rho_yx   <= rho_fin[2];
         rsp_ff.rho_yy   <= rho_fin[3];
         rsp_ff.status   <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // every beat taken comes out after the fixed pipeline depth
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(LAST+1) rsp_valid)
      else $error("result strobe missing after pipeline depth");

   // a zero determinant zeroes every result field; checked on phase_xx, phase_yy, rho_xx and rho_yy
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status) |->
         (rsp_data.phase_xx == '0 && rsp_data.phase_yy == '0 &&
          rsp_data.rho_xx == '0 && rsp_data.rho_yy == '0))
      else $error("results not cleared on zero determinant");

   // phases stay within plus or minus ninety degrees; checked on phase_xy and phase_yx
   a_phase_rng: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ($signed(rsp_data.phase_xy) <= 16'sd23040 &&
          $signed(rsp_data.phase_xy) >= -16'sd23040 &&
          $signed(rsp_data.phase_yx) <= 16'sd23040 &&
          $signed(rsp_data.phase_yx) >= -16'sd23040))
      else $error("phase out of range");

endmodule
`default_nettype wire

[rtl/mtirp_mul.sv]
// two-stage signed multiplier built from 33x33 partial products
`default_nettype none
module mtirp_mul #(
   parameter int WA = 66,
   parameter int WB = 66
) (
   input  logic                     clock,
   input  logic signed [WA-1:0]     a,
   input  logic signed [WB-1:0]     b,
   output logic signed [WA+WB-1:0]  p
);
   localparam int LW = 32;
   localparam int NA = (WA + LW - 1) / LW;
   localparam int NB = (WB + LW - 1) / LW;
   localparam int WP = WA + WB;

   logic signed [NA*LW-1:0]  ax;
   logic signed [NB*LW-1:0]  bx;
   logic signed [2*LW+1:0]   pp_ff [NA][NB];
   logic signed [WP-1:0]     acc;
   logic signed [WP-1:0]     p_ff;

   assign ax = (NA*LW)'(a);
   assign bx = (NB*LW)'(b);

   for (genvar gi = 0; gi < NA; gi++) begin : g_a
      for (genvar gj = 0; gj < NB; gj++) begin : g_b
         logic signed [LW:0] la;
         logic signed [LW:0] lb;
         // only the top limb carries the sign
         assign la = (gi == NA-1) ? $signed({ax[gi*LW+LW-1], ax[gi*LW +: LW]})
                                  : $signed({1'b0, ax[gi*LW +: LW]});
         assign lb = (gj == NB-1) ? $signed({bx[gj*LW+LW-1], bx[gj*LW +: LW]})
                                  : $signed({1'b0, bx[gj*LW +: LW]});
         always_ff @(posedge clock) begin
            pp_ff[gi][gj] <= la * lb;
         end
      end
   end

   always_comb begin
      acc = '0;
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            acc = acc + (WP'(pp_ff[i][j]) <<< (LW*(i+j)));
         end
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= acc;
   end

   assign p = p_ff;

endmodule
`default_nettype wire

[rtl/mtirp_norm_cell.sv]
// one normalize cell: shifts both magnitudes right by SHIFT when the larger exceeds 29+SHIFT bits
`default_nettype none
module mtirp_norm_cell import mtirp_pkg::*; #(
   parameter int SHIFT = 1
) (
   input  logic     clock,
   input  norm_type cell_i,
   output norm_type cell_o
);
   norm_type cell_in;
   norm_type cell_ff;

   always_comb begin
      cell_in = cell_i;
      if (cell_i.mx[PW-1:FIT_BITS-1+SHIFT] != '0) begin
         cell_in.xa = cell_i.xa >> SHIFT;
         cell_in.ya = cell_i.ya >> SHIFT;
         cell_in.mx = cell_i.mx >> SHIFT;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   assign cell_o = cell_ff;

endmodule
`default_nettype wire

[rtl/mtirp_cordic_cell.sv]
// one vectoring cordic iteration with its angle constant
`default_nettype none
module mtirp_cordic_cell import mtirp_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic     clock,
   input  cord_type cell_i,
   output cord_type cell_o
);
   cord_type             cell_in;
   cord_type             cell_ff;
   logic signed [XW-1:0] xs;
   logic signed [XW-1:0] ys;

   always_comb begin
      cell_in = cell_i;
      xs = $signed(cell_i.x) >>> STEP;
      ys = $signed(cell_i.y) >>> STEP;
      if (!cell_i.y[XW-1]) begin
         cell_in.x = cell_i.x + ys;
         cell_in.y = cell_i.y - xs;
         cell_in.z = cell_i.z + ATAN_TBL[STEP];
      end else begin
         cell_in.x = cell_i.x - ys;
         cell_in.y = cell_i.y + xs;
         cell_in.z = cell_i.z - ATAN_TBL[STEP];
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   assign cell_o = cell_ff;

endmodule
`default_nettype wire

[rtl/mtirp_div_cell.sv]
// one restoring division cell, settles one quotient bit
`default_nettype none
module mtirp_div_cell import mtirp_pkg::*; #(
   parameter int BIT = 0
) (
   input  logic    clock,
   input  div_type cell_i,
   output div_type cell_o
);
   div_type       cell_in;
   div_type       cell_ff;
   logic [QW-1:0] sub_w;
   logic [QW:0]   diff;

   always_comb begin
      cell_in = cell_i;
      sub_w   = QW'(cell_i.den) << BIT;
      diff    = {1'b0, cell_i.rem} - {1'b0, sub_w};
      if (!diff[QW]) begin
         cell_in.rem      = diff[QW-1:0];
         cell_in.quo[BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   assign cell_o = cell_ff;

endmodule
`default_nettype wire

[tb/mt_impedance_resistivity_phase_core_test.sv]
// self-checking testbench for the impedance tensor, resistivity and phase core
`timescale 1ns / 100ps
module mt_impedance_resistivity_phase_core_test;
   import mtirp_pkg::*;

   localparam int LATENCY   = 58;
   localparam int MAX_CYCLE = 400000;
   localparam logic [RW-1:0] RHO_SAT = {RW{1'b1}};

   typedef logic signed [191:0] wint;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          start = 1'b0;
   logic          busy;
   req_type       req_data = '0;
   logic          rsp_valid;
   rsp_type       rsp_data;
   logic          csr_we = 1'b0;
   logic [RW-1:0] csr_wdata = '0;

   logic [RW-1:0] scale_reg = '0;      // copy of inv_omega_mu
   rsp_type       station_q[$];
   int            n_err = 0;
   int            n_beats = 0;
   int            n_results = 0;
   int            n_det_zero = 0;
   int            n_cfg = 0;
   longint        cycle = 0;

   mt_impedance_resistivity_phase_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > MAX_CYCLE) begin
         $display("timeout after %0d cycles, %0d results pending", cycle, station_q.size());
         $display("mt_impedance_resistivity_phase_core: mismatch");
         $finish;
      end
   end

   // ---------------- predictor ----------------
   function automatic wint part_re(logic [63:0] v);
      wint r;
      r = $signed(v[63:32]);
      return r;
   endfunction

   function automatic wint part_im(logic [63:0] v);
      wint r;
      r = $signed(v[31:0]);
      return r;
   endfunction

   // a*d - b*c for complex a, b, c, d given as packed fields
   function automatic void cross_diff(logic [63:0] a, logic [63:0] d, logic [63:0] b,
                                      logic [63:0] c, output wint re, output wint im);
      re = part_re(a) * part_re(d) - part_im(a) * part_im(d)
         - (part_re(b) * part_re(c) - part_im(b) * part_im(c));
      im = part_re(a) * part_im(d) + part_im(a) * part_re(d)
         - (part_re(b) * part_im(c) + part_im(b) * part_re(c));
   endfunction

   function automatic logic signed [15:0] phase_deg(wint pre, wint pim);
      logic [191:0] xa, ya, mx;
      int           len;
      longint       x, y, z, xs, ys, mag;
      longint       atan_q16 [20] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                      58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                      229, 115, 57, 29, 14, 7};
      if (pim == 0) return 16'sd0;
      if (pre == 0) return (pim < 0) ? 16'sd23040 : -16'sd23040;
      xa = (pre < 0) ? -pre : pre;
      ya = (pim < 0) ? -pim : pim;
      mx = (xa >= ya) ? xa : ya;
      len = 0;
      for (int i = 191; i >= 0; i--)
         if (len == 0 && mx[i]) len = i + 1;
      if (len > 30) begin
         xa = xa >> (len - 30);
         ya = ya >> (len - 30);
      end
      x = xa[63:0];
      y = ya[63:0];
      z = 0;
      for (int k = 0; k < 20; k++) begin
         xs = x >>> k;
         ys = y >>> k;
         if (y >= 0) begin
            x += ys; y -= xs; z += atan_q16[k];
         end else begin
            x -= ys; y += xs; z -= atan_q16[k];
         end
      end
      if (z < 0) z = 0;
      mag = (z + 128) >>> 8;
      if (mag > PHASE_LIM) mag = PHASE_LIM;
      // ratio positive gives a negative phase
      if ((pim < 0) == (pre < 0)) mag = -mag;
      return mag[15:0];
   endfunction

   function automatic logic [RW-1:0] resistivity(wint nmag2, wint dmag2);
      logic [191:0] q;
      q = (192'(unsigned'(nmag2)) * 192'(scale_reg)) / 192'(unsigned'(dmag2));
      if (q > 192'(RHO_SAT)) return RHO_SAT;
      return q[RW-1:0];
   endfunction

   function automatic rsp_type station_result(req_type r);
      rsp_type o;
      wint     dre, dim, nre[4], nim[4], pre, pim, dm2, nm2;
      logic signed [15:0] ph[4];
      logic [RW-1:0]      rh[4];
      o = '0;
      cross_diff(r.hx_pol1, r.hy_pol2, r.hy_pol1, r.hx_pol2, dre, dim);
      if (dre == 0 && dim == 0) begin
         o.status = 1'b1;
         return o;
      end
      cross_diff(r.ex_pol1, r.hy_pol2, r.ex_pol2, r.hy_pol1, nre[0], nim[0]);
      cross_diff(r.ex_pol2, r.hx_pol1, r.ex_pol1, r.hx_pol2, nre[1], nim[1]);
      cross_diff(r.ey_pol1, r.hy_pol2, r.ey_pol2, r.hy_pol1, nre[2], nim[2]);
      cross_diff(r.ey_pol2, r.hx_pol1, r.ey_pol1, r.hx_pol2, nre[3], nim[3]);
      dm2 = dre * dre + dim * dim;
      for (int k = 0; k < 4; k++) begin
         pre = nre[k] * dre + nim[k] * dim;
         pim = nim[k] * dre - nre[k] * dim;
         nm2 = nre[k] * nre[k] + nim[k] * nim[k];
         ph[k] = phase_deg(pre, pim);
         rh[k] = resistivity(nm2, dm2);
      end
      o.phase_xx = ph[0]; o.phase_xy = ph[1]; o.phase_yx = ph[2]; o.phase_yy = ph[3];
      o.rho_xx = rh[0];   o.rho_xy = rh[1];   o.rho_yx = rh[2];   o.rho_yy = rh[3];
      o.status = 1'b0;
      return o;
   endfunction

   // ---------------- checking ----------------
   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("result %0d field %s: got %h, want %h", n_results, field, got, want);
      n_err++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (station_q.size() == 0) begin
            $display("result %0d arrived with none outstanding", n_results);
            n_err++;
         end else begin
            want = station_q.pop_front();
            if (rsp_data.phase_xx !== want.phase_xx)
               report_mismatch("phase_xx", 64'(rsp_data.phase_xx), 64'(want.phase_xx));
            if (rsp_data.phase_xy !== want.phase_xy)
               report_mismatch("phase_xy", 64'(rsp_data.phase_xy), 64'(want.phase_xy));
            if (rsp_data.phase_yx !== want.phase_yx)
               report_mismatch("phase_yx", 64'(rsp_data.phase_yx), 64'(want.phase_yx));
            if (rsp_data.phase_yy !== want.phase_yy)
               report_mismatch("phase_yy", 64'(rsp_data.phase_yy), 64'(want.phase_yy));
            if (rsp_data.rho_xx !== want.rho_xx)
               report_mismatch("rho_xx", 64'(rsp_data.rho_xx), 64'(want.rho_xx));
            if (rsp_data.rho_xy !== want.rho_xy)
               report_mismatch("rho_xy", 64'(rsp_data.rho_xy), 64'(want.rho_xy));
            if (rsp_data.rho_yx !== want.rho_yx)
               report_mismatch("rho_yx", 64'(rsp_data.rho_yx), 64'(want.rho_yx));
            if (rsp_data.rho_yy !== want.rho_yy)
               report_mismatch("rho_yy", 64'(rsp_data.rho_yy), 64'(want.rho_yy));
            if (rsp_data.status !== want.status)
               report_mismatch("status", 64'(rsp_data.status), 64'(want.status));
         end
         n_results++;
      end
   end

   // ---------------- stimulus helpers ----------------
   function automatic logic [63:0] cpx(logic [31:0] re, logic [31:0] im);
      return {re, im};
   endfunction

   // one start beat, held until taken
   task automatic send_station(req_type r);
      rsp_type want;
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      want = station_result(r);
      if (want.status) n_det_zero++;
      station_q.push_back(want);
      n_beats++;
   endtask

   task automatic idle(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (station_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic set_scale(logic [RW-1:0] v);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      scale_reg  = v;
      n_cfg++;
   endtask

   function automatic logic [31:0] rand_comp();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 8191)) - 4096) << $urandom_range(0, 19);
         2: return 32'h0;
         3: return 32'h8000_0000;
         4: return 32'h7fff_ffff;
         default: return 32'($signed($urandom_range(0, 511)) - 256) << 24;
      endcase
   endfunction

   function automatic req_type rand_station();
      req_type r;
      logic [63:0] f[8];
      int mode;
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 8; i++)
         f[i] = (mode < 4) ? {$urandom, $urandom} : cpx(rand_comp(), rand_comp());
      if (mode == 9) begin
         // identical field pairs give a zero determinant
         f[6] = f[2];
         f[7] = f[3];
      end
      r = '{f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7]};
      return r;
   endfunction

   // ---------------- tests ----------------
   localparam logic [63:0] ONE = 64'h0100_0000_0000_0000;

   task automatic test_directed();
      req_type r;
      // zero determinant, all fields zero
      send_station('0);
      // unit magnetics, so each Z element is the electric field itself
      r = '{cpx(32'h0, 32'h0100_0000), cpx(32'h0, 32'hff00_0000), ONE, 64'h0,
            cpx(32'h0300_0000, 32'h0), cpx(32'h0200_0000, 32'h0200_0000), 64'h0, ONE};
      send_station(r);
      r.ex_pol1 = cpx(32'h0, 32'h0);
      r.ey_pol1 = cpx(32'hfe00_0000, 32'h0);
      r.ex_pol2 = cpx(32'hff00_0000, 32'h0080_0000);
      send_station(r);
      // extremes of every component
      send_station({16{32'h8000_0000}});
      send_station({16{32'h7fff_ffff}});
      send_station({8{cpx(32'h7fff_ffff, 32'h8000_0000)}});
      send_station({8{cpx(32'h8000_0000, 32'h7fff_ffff)}});
      send_station({8{64'hffff_ffff_ffff_ffff}});
      // tiny determinant against large fields drives rho to saturation
      r = '{{2{32'h7fff_ffff}}, {2{32'h8000_0000}}, cpx(32'h1, 32'h0), 64'h0,
            {2{32'h7fff_ffff}}, cpx(32'h8000_0000, 32'h1), 64'h0, cpx(32'h0, 32'h1)};
      send_station(r);
      // determinant zero with nonzero fields
      r = {8{64'h1234_5678_9abc_def0}};
      send_station(r);
      r = '{ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE};
      send_station(r);
      r = '{cpx(32'h0, 32'h1), cpx(32'h1, 32'h0), cpx(32'h0, 32'hffff_ffff), ONE,
            cpx(32'hffff_ffff, 32'h0), cpx(32'h0, 32'h0), ONE, cpx(32'h0, 32'h1)};
      send_station(r);
      idle(1);
   endtask

   task automatic test_random(int n);
      int sent, burst;
      sent = 0;
      while (sent < n) begin
         burst = $urandom_range(1, 30);
         for (int i = 0; i < burst && sent < n; i++) begin
            send_station(rand_station());
            sent++;
         end
         if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 12));
      end
      start <= 1'b0;
   endtask

   task automatic test_pause();
      test_random(40);
      // hold off until the pipeline has emptied, then continue
      start <= 1'b0;
      while (station_q.size() != 0) @(posedge clock);
      test_random(40);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();              // scale register still at its reset value
      set_scale(48'h0000_0001_0000);
      test_directed();
      test_random(150);
      set_scale(RHO_SAT);
      test_directed();
      test_random(150);
      set_scale(48'h0000_0000_0001);
      test_random(120);
      set_scale('0);
      test_random(60);
      set_scale(RW'({$urandom, $urandom}));
      test_pause();
      test_random(150);
      set_scale(48'h0003_d090_0000);
      test_random(100);
      drain();
      $display("%0d station beats, %0d results, %0d zero determinants, %0d scale writes",
               n_beats, n_results, n_det_zero, n_cfg);
      $display("covered sign and zero phase cases, rho saturation and scale extremes");
      if (n_err == 0 && station_q.size() == 0) begin
         $display("mt_impedance_resistivity_phase_core: match");
      end else begin
         $display("mt_impedance_resistivity_phase_core: mismatch");
      end
      $finish;
   end

endmodule
